/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define CHECK_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every clock edge, reset included
`define CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/cau_pkg.sv */
// shared types, constants and tables of the console audio unit
package cau_pkg;
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [4:0] OFS_STATUS = 5'h15;
   localparam logic [4:0] OFS_FRAME  = 5'h17;

   localparam logic [12:0] FRAME_TICKS = 13'd7457;
   localparam logic [15:0] PERIOD_MAX  = 16'h07ff;
   localparam logic [3:0]  ENV_TOP     = 4'd15;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] ofs;
      logic [7:0] wd;
   } req_type;

   typedef struct packed {
      logic [7:0] rd;
      logic [3:0] p1;
      logic [3:0] p2;
      logic [3:0] tri_lvl;
      logic [3:0] noise_lvl;
      logic [6:0] dmc;
      logic       irq;
   } rsp_type;

   function automatic logic [7:0] len_lookup(input logic [4:0] i);
      logic [7:0] r;
      begin
         unique case (i)
            5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
            5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
            5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
            5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
            5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
            5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
            5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
            5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
         endcase
         return r;
      end
   endfunction

   function automatic logic [11:0] nper_lookup(input logic [3:0] i);
      logic [11:0] r;
      begin
         unique case (i)
            4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
            4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
            4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
            4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] duty_lookup(input logic [1:0] i);
      logic [7:0] r;
      begin
         unique case (i)
            2'd0: r = 8'h02;
            2'd1: r = 8'h06;
            2'd2: r = 8'h1e;
            default: r = 8'hf9;
         endcase
         return r;
      end
   endfunction

   // envelope word: bit8 start, bits7..4 divider, bits3..0 level
   function automatic logic [8:0] env_clock(input logic [8:0] env, input logic [3:0] vol,
                                            input logic lp);
      logic [3:0] lvl;
      logic [3:0] dv;
      begin
         lvl = env[3:0];
         dv  = env[7:4];
         if (env[8]) begin
            lvl = ENV_TOP;
            dv  = vol;
         end else if (dv == 4'd0) begin
            dv = vol;
            if (lvl != 4'd0) lvl = lvl - 4'd1;
            else if (lp) lvl = ENV_TOP;
         end else begin
            dv = dv - 4'd1;
         end
         return {1'b0, dv, lvl};
      end
   endfunction
endpackage

/* hdl/console_audio_unit.sv */
// top level of the console audio unit
// usage:
//   req channel carries one request per cpu cycle tick, register write or read;
//   req_op selects which, req_reg_offset is the address minus 0x4000
//   rsp channel returns exactly one result per request: status read data and
//   every channel's output level as it stands after that request
// latency: a result is presented the cycle after its request is accepted
// throughput: one request per clock while req_stall is low; all channel state
//   updates in a single combinational pass feeding the state and result registers
// stall: req_stall is high only while a result is held and rsp_stall is high,
//   so a request enters every cycle when the receiver takes results
// reset: synchronous; core state clears (result data does not), noise shift
//   register loads one, rsp_valid drops, and the block accepts requests in the next cycle
// frame sequencer steps every 7457 ticks; in mode 0, uninhibited, sets rsp_frame_interrupt
module console_audio_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [4:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_pulse_one_level,
   output logic [3:0] rsp_pulse_two_level,
   output logic [3:0] rsp_triangle_level,
   output logic [3:0] rsp_noise_level,
   output logic [6:0] rsp_dmc_level,
   output logic       rsp_frame_interrupt
);
   import cau_pkg::*;
`include "assert_macros.svh"

   logic    go, vld_ff, vld_in;
   req_type req;
   rsp_type nxt, res_ff, res_in;

   assign req_stall = vld_ff && rsp_stall;
   assign go = req_valid && !req_stall;
   assign req = '{op: req_op, ofs: req_reg_offset, wd: req_write_data};

   cau_core u_core (.clock, .reset, .go, .req, .rsp(nxt));

   assign vld_in = go ? 1'b1 : (rsp_stall ? vld_ff : 1'b0);
   assign res_in = go ? nxt : res_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_read_data = res_ff.rd;
   assign rsp_pulse_one_level = res_ff.p1;
   assign rsp_pulse_two_level = res_ff.p2;
   assign rsp_triangle_level = res_ff.tri_lvl;
   assign rsp_noise_level = res_ff.noise_lvl;
   assign rsp_dmc_level = res_ff.dmc;
   assign rsp_frame_interrupt = res_ff.irq;

   `CHECK_CLK(a_accept_gives_result, clock, reset, go |=> rsp_valid, "request lost")
   `CHECK_CLK(a_read_clears_irq, clock, reset,
      (go && req_op == OP_READ && req_reg_offset == OFS_STATUS) |=> !rsp_frame_interrupt,
      "status read left irq set")
   `CHECK_CLK(a_rd_zero, clock, reset,
      (go && req_op != OP_READ) |=> rsp_read_data == 8'd0, "read data on non-read")
endmodule

/* hdl/cau_pulse.sv */
// one pulse channel: timer, sequencer, envelope, sweep and length
module cau_pulse #(
   parameter bit SUB_EXTRA = 1'b1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       tick_en,
   input  logic       half_tick,
   input  logic       quarter_tick,
   input  logic       wr_en,
   input  logic [1:0] wr_reg,
   input  logic [7:0] wr_data,
   input  logic       clear_len,
   output logic       len_active,
   output logic [3:0] level
);
   import cau_pkg::*;

   logic [7:0]  ctl_ff, ctl_in, swp_ff, swp_in, len_ff, len_in;
   logic [15:0] per_ff, per_in, tmr_ff, tmr_in, chg;
   logic [2:0]  seq_ff, seq_in;
   logic [8:0]  env_ff, env_in;
   logic [3:0]  sdv_ff, sdv_in;
   logic [7:0]  duty;

   always_comb begin
      ctl_in = ctl_ff; swp_in = swp_ff; len_in = len_ff; per_in = per_ff;
      tmr_in = tmr_ff; seq_in = seq_ff; env_in = env_ff; sdv_in = sdv_ff;
      chg = per_ff >> swp_ff[2:0];
      if (tick_en) begin
         if (tmr_ff == 16'd0) begin
            tmr_in = per_ff;
            seq_in = seq_ff + 3'd1;
         end else begin
            tmr_in = tmr_ff - 16'd1;
         end
      end
      if (quarter_tick) env_in = env_clock(env_ff, ctl_ff[3:0], ctl_ff[5]);
      if (half_tick) begin
         if (!ctl_ff[5] && len_ff != 8'd0) len_in = len_ff - 8'd1;
         if (sdv_ff[2:0] == 3'd0 && swp_ff[7]) begin
            if (swp_ff[3]) per_in = per_ff - chg - {15'd0, SUB_EXTRA};
            else per_in = per_ff + chg;
         end
         if (sdv_ff[2:0] == 3'd0 || sdv_ff[3]) sdv_in = {1'b0, swp_ff[6:4]};
         else sdv_in = sdv_ff - 4'd1;
      end
      if (wr_en) begin
         case (wr_reg)
            2'd0: ctl_in = wr_data;
            2'd1: begin
               swp_in = wr_data;
               sdv_in[3] = 1'b1;
            end
            2'd2: per_in = {5'd0, per_ff[10:8], wr_data};
            default: begin
               per_in = {5'd0, wr_data[2:0], per_ff[7:0]};
               len_in = len_lookup(wr_data[7:3]);
               seq_in = 3'd0;
               env_in[8] = 1'b1;
            end
         endcase
      end
      if (clear_len) len_in = 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0; swp_ff <= '0; len_ff <= '0; per_ff <= '0;
         tmr_ff <= '0; seq_ff <= '0; env_ff <= '0; sdv_ff <= '0;
      end else begin
         ctl_ff <= ctl_in; swp_ff <= swp_in; len_ff <= len_in; per_ff <= per_in;
         tmr_ff <= tmr_in; seq_ff <= seq_in; env_ff <= env_in; sdv_ff <= sdv_in;
      end
   end

   assign duty = duty_lookup(ctl_in[7:6]);
   assign len_active = (len_in != 8'd0);
   assign level = (len_in == 8'd0 || per_in < 16'd8 || per_in > PERIOD_MAX
                   || !duty[seq_in]) ? 4'd0
                  : (ctl_in[4] ? ctl_in[3:0] : env_in[3:0]);
endmodule

/* hdl/cau_core.sv */
// frame sequencer, triangle, noise, dmc level and status logic
module cau_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  cau_pkg::req_type req,
   output cau_pkg::rsp_type rsp
);
   import cau_pkg::*;

   logic        par_ff, par_in, mode_ff, mode_in, inh_ff, inh_in, irq_ff, irq_in;
   logic [12:0] fdiv_ff, fdiv_in;
   logic [2:0]  fstep_ff, fstep_in, st;
   logic [7:0]  tctl_ff, tctl_in, tlen_ff, tlen_in, tlin_ff, tlin_in;
   logic [10:0] tper_ff, tper_in, ttmr_ff, ttmr_in;
   logic [4:0]  tseq_ff, tseq_in;
   logic [6:0]  nctl_ff, nctl_in, dlv_ff, dlv_in;
   logic [11:0] nper_ff, nper_in, ntmr_ff, ntmr_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic [7:0]  nlen_ff, nlen_in;
   logic [8:0]  nenv_ff, nenv_in;
   logic        is_tick, is_wr, qtr, hlf, ptick, fb;
   logic        p1_act, p2_act;
   logic [3:0]  p1_lvl, p2_lvl;
   logic [4:0]  tri_idx;
   logic [6:0]  lin;
   logic [7:0]  rd;

   assign is_tick = go && req.op == OP_TICK;
   assign is_wr   = go && req.op == OP_WRITE;
   assign ptick   = is_tick && par_ff;

   always_comb begin
      par_in = par_ff; mode_in = mode_ff; inh_in = inh_ff; irq_in = irq_ff;
      fdiv_in = fdiv_ff; fstep_in = fstep_ff;
      tctl_in = tctl_ff; tlen_in = tlen_ff; tlin_in = tlin_ff; tper_in = tper_ff;
      ttmr_in = ttmr_ff; tseq_in = tseq_ff; nctl_in = nctl_ff; dlv_in = dlv_ff;
      nper_in = nper_ff; ntmr_in = ntmr_ff; lfsr_in = lfsr_ff; nlen_in = nlen_ff;
      nenv_in = nenv_ff; qtr = 1'b0; hlf = 1'b0; rd = 8'd0;
      lin = tlin_ff[6:0];
      st = fstep_ff + 3'd1;
      fb = nctl_ff[6] ? (lfsr_ff[6] ^ lfsr_ff[0]) : (lfsr_ff[1] ^ lfsr_ff[0]);
      if (is_tick) begin
         par_in = ~par_ff;
         if (ttmr_ff == 11'd0) begin
            ttmr_in = tper_ff;
            if (tlen_ff != 8'd0 && tlin_ff[6:0] != 7'd0) tseq_in = tseq_ff + 5'd1;
         end else begin
            ttmr_in = ttmr_ff - 11'd1;
         end
         if (par_ff) begin
            if (ntmr_ff == 12'd0) begin
               ntmr_in = nper_ff;
               lfsr_in = {fb, lfsr_ff[14:1]};
            end else begin
               ntmr_in = ntmr_ff - 12'd1;
            end
         end
         if (fdiv_ff + 13'd1 >= FRAME_TICKS) begin
            fdiv_in = 13'd0;
            if (st == 3'd1 || st == 3'd3) qtr = 1'b1;
            if (st == 3'd2 || st == {2'b10, mode_ff}) begin
               qtr = 1'b1; hlf = 1'b1;
            end
            if (st >= {2'b10, mode_ff}) begin
               fstep_in = 3'd0;
               if (!mode_ff && !inh_ff) irq_in = 1'b1;
            end else begin
               fstep_in = st;
            end
         end else begin
            fdiv_in = fdiv_ff + 13'd1;
         end
      end
      if (is_wr && req.ofs == OFS_FRAME) begin
         mode_in = req.wd[7];
         inh_in = req.wd[6];
         if (req.wd[6]) irq_in = 1'b0;
         fstep_in = 3'd0;
         if (req.wd[7]) begin
            qtr = 1'b1; hlf = 1'b1;
         end
      end
      if (qtr) begin
         nenv_in = env_clock(nenv_ff, nctl_ff[3:0], nctl_ff[5]);
         lin = tlin_ff[7] ? tctl_ff[6:0]
               : (tlin_ff[6:0] != 7'd0 ? tlin_ff[6:0] - 7'd1 : 7'd0);
         tlin_in = {tlin_ff[7] & tctl_ff[7], lin};
      end
      if (hlf) begin
         if (!tctl_ff[7] && tlen_ff != 8'd0) tlen_in = tlen_ff - 8'd1;
         if (!nctl_ff[5] && nlen_ff != 8'd0) nlen_in = nlen_ff - 8'd1;
      end
      if (is_wr) begin
         case (req.ofs)
            5'h08: tctl_in = req.wd;
            5'h0a: tper_in = {tper_ff[10:8], req.wd};
            5'h0b: begin
               tper_in = {req.wd[2:0], tper_ff[7:0]};
               tlen_in = len_lookup(req.wd[7:3]);
               tlin_in[7] = 1'b1;
            end
            5'h0c: nctl_in = {nctl_ff[6], req.wd[5:0]};
            5'h0e: begin
               nctl_in[6] = req.wd[7];
               nper_in = nper_lookup(req.wd[3:0]);
            end
            5'h0f: begin
               nlen_in = len_lookup(req.wd[7:3]);
               nenv_in[8] = 1'b1;
            end
            5'h11: dlv_in = req.wd[6:0];
            OFS_STATUS: begin
               if (!req.wd[2]) tlen_in = 8'd0;
               if (!req.wd[3]) nlen_in = 8'd0;
            end
            default: ;
         endcase
      end
      if (go && req.op == OP_READ && req.ofs == OFS_STATUS) begin
         rd = {1'b0, irq_ff, 2'b00, nlen_ff != 8'd0, tlen_ff != 8'd0, p2_act, p1_act};
         irq_in = 1'b0;
      end
   end

   cau_pulse #(.SUB_EXTRA(1'b1)) u_pulse_one (
      .clock, .reset, .tick_en(ptick), .half_tick(hlf), .quarter_tick(qtr),
      .wr_en(is_wr && req.ofs[4:2] == 3'd0), .wr_reg(req.ofs[1:0]), .wr_data(req.wd),
      .clear_len(is_wr && req.ofs == OFS_STATUS && !req.wd[0]),
      .len_active(p1_act), .level(p1_lvl));

   cau_pulse #(.SUB_EXTRA(1'b0)) u_pulse_two (
      .clock, .reset, .tick_en(ptick), .half_tick(hlf), .quarter_tick(qtr),
      .wr_en(is_wr && req.ofs[4:2] == 3'd1), .wr_reg(req.ofs[1:0]), .wr_data(req.wd),
      .clear_len(is_wr && req.ofs == OFS_STATUS && !req.wd[1]),
      .len_active(p2_act), .level(p2_lvl));

   always_ff @(posedge clock) begin
      if (reset) begin
         par_ff <= 1'b0; mode_ff <= 1'b0; inh_ff <= 1'b0; irq_ff <= 1'b0;
         fdiv_ff <= '0; fstep_ff <= '0; tctl_ff <= '0; tlen_ff <= '0; tlin_ff <= '0;
         tper_ff <= '0; ttmr_ff <= '0; tseq_ff <= '0; nctl_ff <= '0; dlv_ff <= '0;
         nper_ff <= '0; ntmr_ff <= '0; lfsr_ff <= 15'd1; nlen_ff <= '0; nenv_ff <= '0;
      end else begin
         par_ff <= par_in; mode_ff <= mode_in; inh_ff <= inh_in; irq_ff <= irq_in;
         fdiv_ff <= fdiv_in; fstep_ff <= fstep_in; tctl_ff <= tctl_in; tlen_ff <= tlen_in;
         tlin_ff <= tlin_in; tper_ff <= tper_in; ttmr_ff <= ttmr_in; tseq_ff <= tseq_in;
         nctl_ff <= nctl_in; dlv_ff <= dlv_in; nper_ff <= nper_in; ntmr_ff <= ntmr_in;
         lfsr_ff <= lfsr_in; nlen_ff <= nlen_in; nenv_ff <= nenv_in;
      end
   end

   assign tri_idx = tseq_in;
   always_comb begin
      rsp.rd = rd;
      rsp.p1 = p1_lvl;
      rsp.p2 = p2_lvl;
      rsp.tri_lvl = (tlen_in != 8'd0 && tlin_in[6:0] != 7'd0 && tper_in >= 11'd2)
                    ? (tri_idx[4] ? tri_idx[3:0] : ~tri_idx[3:0]) : 4'd0;
      rsp.noise_lvl = (nlen_in != 8'd0 && !lfsr_in[0])
                      ? (nctl_in[4] ? nctl_in[3:0] : nenv_in[3:0]) : 4'd0;
      rsp.dmc = dlv_in;
      rsp.irq = irq_in;
   end
endmodule
